// ===== sv/mm2_pkg.sv =====
package mm2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [31:0] SEED_RESET = 32'd97;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT1 = 13;
  localparam int unsigned FIN_SHIFT2 = 15;

  // config port: one 32-bit register, word index taken from paddr[2]
  localparam int unsigned ADDR_W   = 3;
  localparam logic        REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HM,
    S_MIXD,
    S_TAIL,
    S_TAILD,
    S_FIN,
    S_FIND
  } state_t;

endpackage

// ===== sv/mm2_mul.sv =====
module mm2_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  output logic [31:0] p
);
  import mm2_pkg::*;

  logic [31:0] p_r;
  logic [31:0] p_nxt;

  // low 32 bits of a * MIX_MUL, one result per cycle while en is high (the product holds while en is low)
  assign p_nxt = a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== sv/mm2_core.sv =====
module mm2_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_byte,
  input  logic [15:0] in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  output logic        mul_en,
  output logic [31:0] mul_a,
  input  logic [31:0] mul_p
);
  import mm2_pkg::*;

  state_t      state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] len_r, len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic        accept;
  logic        first;
  logic [15:0] len_cur;
  logic [31:0] h_cur;
  logic [23:0] pend_cur;
  logic [23:0] pend_new;
  logic [15:0] seen_inc;
  logic        out_free;
  logic [31:0] fin_hash;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign first    = (seen_r == 16'd0);
  assign len_cur  = first ? in_key_length : len_r;
  assign h_cur    = first ? (seed ^ {16'd0, in_key_length}) : h_r;
  assign pend_cur = first ? 24'd0 : pend_r;
  assign seen_inc = seen_r + 16'd1;
  assign fin_hash = mul_p ^ (mul_p >> FIN_SHIFT2);

  always_comb begin
    pend_new = pend_cur;
    case (seen_r[1:0])
      2'd0:    pend_new[7:0]   = in_key_byte;
      2'd1:    pend_new[15:8]  = in_key_byte;
      2'd2:    pend_new[23:16] = in_key_byte;
      default: pend_new        = pend_cur;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    seen_nxt      = seen_r;
    len_nxt       = len_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_en        = 1'b1;
    mul_a         = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        mul_en = 1'b0;
        if (accept) begin
          h_nxt   = h_cur;
          len_nxt = len_cur;
          if (first && (in_key_length == 16'd0)) begin
            // empty key: straight to the final mix
            pend_nxt  = 24'd0;
            state_nxt = S_FIN;
          end else begin
            seen_nxt = seen_inc;
            if (seen_r[1:0] == 2'd3) begin
              k_nxt     = {in_key_byte, pend_cur};
              pend_nxt  = 24'd0;
              state_nxt = S_K1;
            end else begin
              pend_nxt = pend_new;
              if (seen_inc == len_cur) begin
                state_nxt = S_TAIL;
              end
            end
          end
        end
      end
      S_K1: begin
        mul_a     = k_r;
        state_nxt = S_K2;
      end
      S_K2: begin
        mul_a     = mul_p ^ (mul_p >> MIX_SHIFT);
        state_nxt = S_HM;
      end
      S_HM: begin
        k_nxt     = mul_p;
        mul_a     = h_r;
        state_nxt = S_MIXD;
      end
      S_MIXD: begin
        mul_en    = 1'b0;
        h_nxt     = mul_p ^ k_r;
        state_nxt = (seen_r == len_r) ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        mul_a     = h_r ^ {8'd0, pend_r};
        state_nxt = S_TAILD;
      end
      S_TAILD: begin
        mul_en    = 1'b0;
        h_nxt     = mul_p;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        mul_a     = h_r ^ (h_r >> FIN_SHIFT1);
        state_nxt = S_FIND;
      end
      S_FIND: begin
        // product held until the output register frees up
        mul_en = 1'b0;
        if (out_free) begin
          out_hash_nxt  = fin_hash;
          out_valid_nxt = 1'b1;
          seen_nxt      = 16'd0;
          pend_nxt      = 24'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= 32'd0;
      pend_r      <= 24'd0;
      seen_r      <= 16'd0;
      len_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      pend_r      <= pend_nxt;
      seen_r      <= seen_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ===== sv/murmur2_byte_stream_hash.sv =====
// MurmurHash2 (32-bit) over a key streamed one byte per transfer.
// Input channel: in_valid/in_stall carry in_key_byte and in_key_length; the
// length is sampled on the first byte of each key. A zero-length key takes one
// transfer whose byte is ignored. Result channel: out_valid/out_stall carry
// out_hash_value, one result per key, held in an output register.
// Config: APB-style write of hash_seed at address 0 (reset value 97); the seed
// is picked up at the first byte of the next key.
// Work per input byte, all on one shared 32x32 constant multiplier:
//   byte that does not complete a word: only stored in the partial word
//   byte that completes a word: three multiplies of the word mix
//   last byte of a key: a tail fold unless that byte completes a word, then the
//   final mix; an empty key goes straight to the final mix.
// in_stall is high whenever the sequencer is busy. A new key may start while
// the previous result still waits; if the receiver stalls, the next result
// holds in the final-mix step until the output register is taken.
// Reset (rst_n low at a clock edge) clears the sequencer, drops any pending
// result and restores the seed to 97.
module murmur2_byte_stream_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_key_byte,
  input  logic [15:0]               in_key_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_hash_value,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mm2_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mm2_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_p;

  assign pready = 1'b1;

  always_comb begin
    seed_nxt = seed_r;
    if (psel && penable && pwrite && (paddr[2] == REG_SEED)) begin
      seed_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_SEED) ? seed_r : 32'd0;

  mm2_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_byte    (in_key_byte),
    .in_key_length  (in_key_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .mul_en         (mul_en),
    .mul_a          (mul_a),
    .mul_p          (mul_p)
  );

  mm2_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .p   (mul_p)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mm2_pkg::*;

  localparam logic [ADDR_W-1:0] SEED_ADDR = {REG_SEED, 2'b00};
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 120;

  typedef struct packed {
    logic [7:0]  kbyte;
    logic [15:0] klen;
  } key_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_key_byte = 8'h00;
  logic [15:0] in_key_length = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  murmur2_byte_stream_hash dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_byte    (in_key_byte),
    .in_key_length  (in_key_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow of the block's hashing state
  logic [31:0] seed_shadow = SEED_RESET;
  logic [31:0] run_hash = 32'h0;
  logic [23:0] part_word = 24'h0;
  logic [15:0] bytes_seen = 16'h0;
  logic [15:0] key_len = 16'h0;

  key_item_t   key_stream[$];
  logic [31:0] expected_hashes[$];

  int unsigned fail_count = 0;
  int unsigned hashes_seen = 0;
  bit          idle_on = 1'b1;
  bit          in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          stall_next;
  int unsigned quiet_cycles = 0;
  key_item_t   next_item;

  function automatic logic [31:0] final_mix(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h ^ (h >> FIN_SHIFT1);
    h = h * MIX_MUL;
    h = h ^ (h >> FIN_SHIFT2);
    return h;
  endfunction

  function automatic void murmur_take_byte(input logic [7:0] b, input logic [15:0] len_f);
    logic [31:0] k;
    logic [31:0] h;
    if (bytes_seen == 16'h0) begin
      // 16-bit length can never exceed the 65535 cap
      key_len = len_f;
      run_hash = seed_shadow ^ {16'h0, key_len};
      part_word = 24'h0;
      if (key_len == 16'h0) begin
        expected_hashes.insert(expected_hashes.size(), final_mix(run_hash));
        return;
      end
    end
    if (bytes_seen[1:0] == 2'd3) begin
      k = {b, part_word};
      k = k * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      run_hash = (run_hash * MIX_MUL) ^ k;
      part_word = 24'h0;
    end else begin
      part_word = part_word | (24'(b) << (8 * bytes_seen[1:0]));
    end
    bytes_seen = bytes_seen + 16'd1;
    if (bytes_seen == key_len) begin
      h = run_hash;
      if (key_len[1:0] != 2'd0) begin
        h = h ^ {8'h0, part_word};
        h = h * MIX_MUL;
      end
      expected_hashes.insert(expected_hashes.size(), final_mix(h));
      run_hash = h;
      part_word = 24'h0;
      bytes_seen = 16'h0;
    end
  endfunction

  // input side: predict on each accepted transfer
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      murmur_take_byte(in_key_byte, in_key_length);
  end

  // result side: compare each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      hashes_seen++;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: unexpected result %h", out_hash_value);
        fail_count++;
      end else if (out_hash_value !== expected_hashes[0]) begin
        $error("hash_value: expected %h, actual %h", expected_hashes[0], out_hash_value);
        fail_count++;
        void'(expected_hashes.pop_front());
      end else begin
        void'(expected_hashes.pop_front());
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold the payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (key_stream.size() != 0 && !(idle_on && $urandom_range(0, 7) == 0)) begin
      next_item = key_stream.pop_front();
      in_valid <= 1'b1;
      in_key_byte <= next_item.kbyte;
      in_key_length <= next_item.klen;
    end else begin
      if (key_stream.size() != 0)
        gap_left = $urandom_range(0, 4);
      in_valid <= 1'b0;
    end
  end

  // receiver; one long hold-off once enough results have gone by
  always @(negedge clk) begin
    stall_next = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (!hold_done && hashes_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      stall_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic [15:0] l);
    key_item_t it;
    it.kbyte = b;
    it.klen = l;
    key_stream.insert(key_stream.size(), it);
  endtask

  // later bytes of a key carry a random length that the block must ignore
  task automatic push_key(input int unsigned len);
    push_item(8'($urandom), 16'(len));
    for (int unsigned i = 1; i < len; i++)
      push_item(8'($urandom), 16'($urandom));
  endtask

  task automatic push_random_keys(input int unsigned n_items);
    int unsigned queued;
    int unsigned r;
    int unsigned len;
    queued = 0;
    while (queued < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        len = $urandom_range(65, 300);
      else if (r < 15)
        len = $urandom_range(13, 64);
      else
        len = $urandom_range(0, 12);
      push_key(len);
      queued += (len == 0) ? 1 : len;
    end
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = SEED_ADDR;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    seed_shadow = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (key_stream.size() != 0 || in_valid || expected_hashes.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed keys under the reset seed
    push_item(8'hff, 16'h0000);
    push_item(8'h00, 16'h0000);
    push_item(8'hff, 16'd1);
    push_item(8'h00, 16'd2);
    push_item(8'hff, 16'hffff);
    push_item(8'h80, 16'd3);
    push_item(8'h01, 16'h0000);
    push_item(8'h7f, 16'h8000);
    push_item(8'hff, 16'd4);
    push_item(8'hff, 16'h5555);
    push_item(8'hff, 16'haaaa);
    push_item(8'hff, 16'hffff);
    push_key(5);
    push_key(8);
    drain();

    write_seed(32'h0000_0000);
    push_random_keys(450);
    drain();

    write_seed(32'hffff_ffff);
    push_random_keys(450);
    drain();

    write_seed($urandom);
    push_random_keys(450);
    drain();

    idle_on = 1'b0;
    write_seed($urandom);
    push_random_keys(420);
    drain();

    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ===== murmur2_byte_stream_hash.f =====
sv/mm2_pkg.sv
sv/mm2_mul.sv
sv/mm2_core.sv
sv/murmur2_byte_stream_hash.sv
tb/tb_top.sv
